/* rtl/decimal_big_subtract_macros.svh */
`ifndef DECIMAL_BIG_SUBTRACT_MACROS_SVH
`define DECIMAL_BIG_SUBTRACT_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define DBS_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error("dbs assertion failed");

// Next-cycle implication, held off while reset is asserted.
`define DBS_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error("dbs assertion failed");

`endif

/* rtl/dbs_pkg.sv */
`default_nettype none
package dbs_pkg;

  localparam int DBS_MAX_DIGITS = 64;
  localparam int DIGIT_W        = 4;
  localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;
  localparam logic [DIGIT_W:0]   RADIX     = 5'd10;

  // controller -> datapath
  typedef struct packed {
    logic load;      // input word taken
    logic prep;      // latch width, clear subtract state
    logic sub_step;  // one subtract step on the read data
    logic sel;       // pick sign and first digit to emit
    logic emit_ld;   // load output register from diff store
    logic pop;       // output word taken
  } dbs_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic end_second;  // word on the input ends the subtrahend
    logic sub_done;    // current subtract step is the last one
    logic out_last;    // word in the output register is the last one
  } dbs_status_t;

endpackage
`default_nettype wire

/* rtl/dbs_if.sv */
`default_nettype none
interface dbs_in_if import dbs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [DIGIT_W-1:0] digit;
  logic               last_digit;

  modport source (output valid, output digit, output last_digit, input ready);
  modport sink   (input valid, input digit, input last_digit, output ready);
endinterface

interface dbs_out_if import dbs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               negative;
  logic [DIGIT_W-1:0] result_digit;
  logic               last;
  logic               overflow;

  modport source (output valid, output negative, output result_digit, output last,
                  output overflow, input ready);
  modport sink   (input valid, input negative, input result_digit, input last,
                  input overflow, output ready);
endinterface
`default_nettype wire

/* rtl/dbs_ram.sv */
`default_nettype none
module dbs_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* rtl/dbs_ctrl.sv */
`default_nettype none
module dbs_ctrl import dbs_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        out_ready,
  input  wire dbs_status_t st,
  output dbs_cmd_t         cmd
);

  typedef enum logic [7:0] {
    S_LOAD      = 8'b0000_0001,
    S_PREP      = 8'b0000_0010,
    S_SUB_RD    = 8'b0000_0100,
    S_SUB_WR    = 8'b0000_1000,
    S_SEL       = 8'b0001_0000,
    S_EMIT_RD   = 8'b0010_0000,
    S_EMIT_LD   = 8'b0100_0000,
    S_EMIT_WAIT = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (st.end_second) begin
            state_nxt = S_PREP;
          end
        end
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = S_SUB_RD;
      end
      S_SUB_RD: state_nxt = S_SUB_WR;
      S_SUB_WR: begin
        cmd.sub_step = 1'b1;
        state_nxt    = st.sub_done ? S_SEL : S_SUB_RD;
      end
      S_SEL: begin
        cmd.sel   = 1'b1;
        state_nxt = S_EMIT_RD;
      end
      S_EMIT_RD: state_nxt = S_EMIT_LD;
      S_EMIT_LD: begin
        cmd.emit_ld = 1'b1;
        state_nxt   = S_EMIT_WAIT;
      end
      S_EMIT_WAIT: begin
        if (out_ready) begin
          cmd.pop   = 1'b1;
          state_nxt = st.out_last ? S_LOAD : S_EMIT_RD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

endmodule
`default_nettype wire

/* rtl/dbs_datapath.sv */
`default_nettype none
`include "decimal_big_subtract_macros.svh"
module dbs_datapath import dbs_pkg::*; #(
  parameter int MAX_DIGITS = DBS_MAX_DIGITS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire dbs_cmd_t           cmd,
  output dbs_status_t             st,
  input  wire logic [DIGIT_W-1:0] in_digit,
  input  wire logic               in_last_digit,
  output logic                    out_valid,
  output logic                    out_negative,
  output logic      [DIGIT_W-1:0] out_result_digit,
  output logic                    out_last,
  output logic                    out_overflow
);

  localparam int AW = $clog2(MAX_DIGITS);
  localparam int LW = $clog2(MAX_DIGITS + 1);
  localparam logic [LW-1:0] LEN_MAX = LW'(MAX_DIGITS);
  localparam logic [LW-1:0] LEN_ONE = LW'(1);

  // operand lengths, phase, overflow
  logic [LW-1:0] lm_r, lm_nxt, ls_r, ls_nxt;
  logic          phase_r, phase_nxt, ovf_r, ovf_nxt;
  // subtract pass
  logic [LW-1:0] w_r, w_nxt;
  logic [AW-1:0] j_r, j_nxt;
  logic          bab_r, bab_nxt, bba_r, bba_nxt;
  logic [AW-1:0] first_ab_r, first_ab_nxt, first_ba_r, first_ba_nxt;
  // emit pass
  logic [AW-1:0] e_r, e_nxt;
  logic          neg_r, neg_nxt;
  logic          oval_r, oval_nxt;
  logic [DIGIT_W-1:0] odig_r, odig_nxt;
  logic          olast_r, olast_nxt, oneg_r, oneg_nxt, oovf_r, oovf_nxt;

  logic [DIGIT_W-1:0] dsat;
  logic [LW-1:0]      wmax, wmax_m1, w_m1, jl;
  logic [LW-1:0]      m_idx, s_idx;
  logic [AW-1:0]      k;
  logic               we_m, we_s;
  logic [DIGIT_W-1:0] rd_m, rd_s, rd_ab, rd_ba;
  logic [DIGIT_W-1:0] a, b, d_ab, d_ba;
  logic [DIGIT_W:0]   t_ab, t_ba;
  logic               nb_ab, nb_ba;

  assign dsat    = (in_digit > DIGIT_MAX) ? DIGIT_MAX : in_digit;
  assign we_m    = cmd.load && !phase_r && (lm_r != LEN_MAX);
  assign we_s    = cmd.load &&  phase_r && (ls_r != LEN_MAX);
  assign wmax    = (lm_r > ls_r) ? lm_r : ls_r;
  assign wmax_m1 = wmax - LEN_ONE;
  assign w_m1    = w_r - LEN_ONE;
  assign jl      = LW'(j_r);
  // walk both stores from their least significant digit
  assign m_idx   = lm_r - LEN_ONE - jl;
  assign s_idx   = ls_r - LEN_ONE - jl;
  assign k       = w_m1[AW-1:0] - j_r;

  dbs_ram #(.WIDTH(DIGIT_W), .DEPTH(MAX_DIGITS)) u_min (
    .clk, .we(we_m), .waddr(lm_r[AW-1:0]), .wdata(dsat),
    .raddr(m_idx[AW-1:0]), .rdata(rd_m)
  );
  dbs_ram #(.WIDTH(DIGIT_W), .DEPTH(MAX_DIGITS)) u_sub (
    .clk, .we(we_s), .waddr(ls_r[AW-1:0]), .wdata(dsat),
    .raddr(s_idx[AW-1:0]), .rdata(rd_s)
  );
  dbs_ram #(.WIDTH(DIGIT_W), .DEPTH(MAX_DIGITS)) u_dab (
    .clk, .we(cmd.sub_step), .waddr(k), .wdata(d_ab),
    .raddr(e_r), .rdata(rd_ab)
  );
  dbs_ram #(.WIDTH(DIGIT_W), .DEPTH(MAX_DIGITS)) u_dba (
    .clk, .we(cmd.sub_step), .waddr(k), .wdata(d_ba),
    .raddr(e_r), .rdata(rd_ba)
  );

  // both differences at once; the borrow out of a-b gives the sign
  always_comb begin
    a     = (jl < lm_r) ? rd_m : '0;
    b     = (jl < ls_r) ? rd_s : '0;
    t_ab  = {1'b0, a} - {1'b0, b} - {{DIGIT_W{1'b0}}, bab_r};
    t_ba  = {1'b0, b} - {1'b0, a} - {{DIGIT_W{1'b0}}, bba_r};
    nb_ab = t_ab[DIGIT_W];
    nb_ba = t_ba[DIGIT_W];
    d_ab  = nb_ab ? DIGIT_W'(t_ab + RADIX) : t_ab[DIGIT_W-1:0];
    d_ba  = nb_ba ? DIGIT_W'(t_ba + RADIX) : t_ba[DIGIT_W-1:0];
  end

  always_comb begin
    lm_nxt = lm_r;  ls_nxt = ls_r;  phase_nxt = phase_r;  ovf_nxt = ovf_r;
    w_nxt = w_r;  j_nxt = j_r;  bab_nxt = bab_r;  bba_nxt = bba_r;
    first_ab_nxt = first_ab_r;  first_ba_nxt = first_ba_r;
    e_nxt = e_r;  neg_nxt = neg_r;  oval_nxt = oval_r;
    odig_nxt = odig_r;  olast_nxt = olast_r;  oneg_nxt = oneg_r;  oovf_nxt = oovf_r;

    if (cmd.load) begin
      if (!phase_r) begin
        if (lm_r == LEN_MAX) begin
          ovf_nxt = 1'b1;
        end else begin
          lm_nxt = lm_r + LEN_ONE;
        end
        if (in_last_digit) begin
          phase_nxt = 1'b1;
        end
      end else begin
        if (ls_r == LEN_MAX) begin
          ovf_nxt = 1'b1;
        end else begin
          ls_nxt = ls_r + LEN_ONE;
        end
      end
    end
    if (cmd.prep) begin
      w_nxt        = wmax;
      j_nxt        = '0;
      bab_nxt      = 1'b0;
      bba_nxt      = 1'b0;
      first_ab_nxt = wmax_m1[AW-1:0];
      first_ba_nxt = wmax_m1[AW-1:0];
    end
    if (cmd.sub_step) begin
      j_nxt   = j_r + AW'(1);
      bab_nxt = nb_ab;
      bba_nxt = nb_ba;
      if (d_ab != '0) begin
        first_ab_nxt = k;
      end
      if (d_ba != '0) begin
        first_ba_nxt = k;
      end
    end
    if (cmd.sel) begin
      neg_nxt = bab_r;
      e_nxt   = bab_r ? first_ba_r : first_ab_r;
    end
    if (cmd.emit_ld) begin
      oval_nxt  = 1'b1;
      odig_nxt  = neg_r ? rd_ba : rd_ab;
      olast_nxt = (e_r == w_m1[AW-1:0]);
      oneg_nxt  = neg_r;
      oovf_nxt  = ovf_r;
    end
    if (cmd.pop) begin
      oval_nxt = 1'b0;
      e_nxt    = e_r + AW'(1);
      if (olast_r) begin
        lm_nxt    = '0;
        ls_nxt    = '0;
        phase_nxt = 1'b0;
        ovf_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lm_r       <= '0;
      ls_r       <= '0;
      phase_r    <= 1'b0;
      ovf_r      <= 1'b0;
      w_r        <= '0;
      j_r        <= '0;
      bab_r      <= 1'b0;
      bba_r      <= 1'b0;
      first_ab_r <= '0;
      first_ba_r <= '0;
      e_r        <= '0;
      neg_r      <= 1'b0;
      oval_r     <= 1'b0;
      olast_r    <= 1'b0;
    end else begin
      lm_r       <= lm_nxt;
      ls_r       <= ls_nxt;
      phase_r    <= phase_nxt;
      ovf_r      <= ovf_nxt;
      w_r        <= w_nxt;
      j_r        <= j_nxt;
      bab_r      <= bab_nxt;
      bba_r      <= bba_nxt;
      first_ab_r <= first_ab_nxt;
      first_ba_r <= first_ba_nxt;
      e_r        <= e_nxt;
      neg_r      <= neg_nxt;
      oval_r     <= oval_nxt;
      olast_r    <= olast_nxt;
    end
  end

  always_ff @(posedge clk) begin
    odig_r <= odig_nxt;
    oneg_r <= oneg_nxt;
    oovf_r <= oovf_nxt;
  end

  assign st.end_second  = phase_r && in_last_digit;
  assign st.sub_done    = (j_r == w_m1[AW-1:0]);
  assign st.out_last    = olast_r;

  assign out_valid        = oval_r;
  assign out_negative     = oneg_r;
  assign out_result_digit = odig_r;
  assign out_last         = olast_r;
  assign out_overflow     = oovf_r;

  // last word taken leaves the block ready for a fresh minuend
  `DBS_ASSERT_NXT(a_clear_after_last, clk, rst_n, cmd.pop && olast_r, lm_r == '0 && ls_r == '0 && !phase_r && !ovf_r)
  // emitted digits stay decimal
  `DBS_ASSERT_IMP(a_digit_range, clk, rst_n, oval_r, odig_r <= DIGIT_MAX)
  // subtract walk never runs past the aligned width
  `DBS_ASSERT_IMP(a_step_in_width, clk, rst_n, cmd.sub_step, jl < w_r)

endmodule
`default_nettype wire

/* rtl/decimal_big_subtract.sv */
// decimal_big_subtract: signed difference of two unsigned decimal numbers.
// in_ch  (valid/ready): one digit per word, most significant first; last_digit
//        closes an operand. The first operand is the minuend, the second the
//        subtrahend. Digits above nine are stored as nine.
// out_ch (valid/ready): the difference, most significant digit first, leading
//        zeros dropped, last set on the final word; negative and overflow are
//        the same on every word of one result. Equal operands give a single 0.
// Throughput: a digit is taken every cycle while operands load. The word that
//   ends the subtrahend starts the finish: a prep step, then for each digit of
//   the wider operand a store read followed by a subtract that writes both
//   differences, a select step, then for each output word a diff store read,
//   an output register load and the handshake.
// in_ch.ready is low from that final digit until the last result word has
// been taken. A stalled receiver simply holds the output register; nothing
// is lost. Operands longer than MAX_DIGITS keep their first MAX_DIGITS digits
// and raise overflow on the result.
// Reset (rst_n, synchronous): lengths, phase and overflow cleared, block waits
// for a minuend. Digit stores need no clearing; only written entries are read.
`default_nettype none
module decimal_big_subtract import dbs_pkg::*; #(
  parameter int MAX_DIGITS = DBS_MAX_DIGITS
) (
  input wire logic clk,
  input wire logic rst_n,
  dbs_in_if.sink   in_ch,
  dbs_out_if.source out_ch
);

  dbs_cmd_t    cmd;
  dbs_status_t st;

  // sequencer: load, subtract pass, emit pass
  dbs_ctrl u_ctrl (
    .clk,
    .rst_n,
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .st,
    .cmd
  );

  // digit stores, borrow chains, output word register
  dbs_datapath #(.MAX_DIGITS(MAX_DIGITS)) u_dp (
    .clk,
    .rst_n,
    .cmd,
    .st,
    .in_digit         (in_ch.digit),
    .in_last_digit    (in_ch.last_digit),
    .out_valid        (out_ch.valid),
    .out_negative     (out_ch.negative),
    .out_result_digit (out_ch.result_digit),
    .out_last         (out_ch.last),
    .out_overflow     (out_ch.overflow)
  );

endmodule
`default_nettype wire
